FILE: sv/cthb_pkg.sv
`timescale 1ns / 1ps

package cthb_pkg;

   // request kinds
   localparam logic [1:0] REQ_MOVE = 2'd0;
   localparam logic [1:0] REQ_BOX  = 2'd1;
   localparam logic [1:0] REQ_SET  = 2'd2;

   // register indexes on the csr port
   localparam logic [2:0] CSR_SENSITIVITY   = 3'd0;
   localparam logic [2:0] CSR_FILTER_ENABLE = 3'd1;
   localparam logic [2:0] CSR_CURSOR_LOCK   = 3'd2;
   localparam logic [2:0] CSR_SCREEN_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_SCREEN_HEIGHT = 3'd4;
   localparam logic [2:0] CSR_ITEM_COUNT    = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   typedef struct packed {
      logic signed [13:0] left;
      logic signed [13:0] top;
      logic signed [13:0] right;
      logic signed [13:0] bottom;
      logic               selectable;
   } box_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic mul;
      logic upd;
      logic search;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] kind;
      logic       lock;
      logic       search_needed;
      logic       search_done;
   } status_type;

endpackage

FILE: sv/cthb_ctrl.sv
`timescale 1ns / 1ps

module cthb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  cthb_pkg::status_type st,
   output cthb_pkg::cmd_type   cmd
);
   import cthb_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MUL    = 3'd1;
   localparam logic [2:0] S_UPD    = 3'd2;
   localparam logic [2:0] S_SEARCH = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.accept   = accept;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (st.kind == REQ_MOVE && !st.lock) state_in = S_MUL;
               else                                 state_in = S_OUT;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.upd  = 1'b1;
            state_in = st.search_needed ? S_SEARCH : S_OUT;
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (st.search_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load)     rsp_valid_in = 1'b1;
      else if (!rsp_stall)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/cthb_dpath.sv
`timescale 1ns / 1ps

module cthb_dpath #(
   parameter int MAX_BOXES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cthb_pkg::cmd_type    cmd,
   output cthb_pkg::status_type st,
   input  logic                 csr_we,
   input  logic [cthb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cthb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [1:0]           req_type,
   input  logic signed [11:0]   req_delta_x,
   input  logic signed [11:0]   req_delta_y,
   input  logic [5:0]           req_box_index,
   input  logic signed [13:0]   req_box_left,
   input  logic signed [13:0]   req_box_top,
   input  logic signed [13:0]   req_box_right,
   input  logic signed [13:0]   req_box_bottom,
   input  logic                 req_box_selectable,
   input  logic [15:0]          req_new_pos_x,
   input  logic [15:0]          req_new_pos_y,
   output logic [15:0]          rsp_cursor_x,
   output logic [15:0]          rsp_cursor_y,
   output logic                 rsp_over_item,
   output logic [5:0]           rsp_hover_index,
   output logic [5:0]           rsp_selected_index,
   output logic                 rsp_new_item
);
   import cthb_pkg::*;

   localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CW = $clog2(MAX_BOXES + 1);
   localparam logic [8:0] MAX_N = 9'(MAX_BOXES);

   // configuration
   logic [11:0] sens_ff;
   logic        filt_ff;
   logic        lock_ff;
   logic [12:0] width_ff;
   logic [12:0] height_ff;
   logic [6:0]  items_ff;

   // cursor and search state
   logic [15:0] pos_x_ff, pos_x_in;
   logic [15:0] pos_y_ff, pos_y_in;
   logic        hover_ff;
   logic [5:0]  hover_idx_ff;
   logic [5:0]  sel_ff;
   logic        changed_ff;

   logic signed [11:0] dx_ff, dy_ff;
   logic signed [24:0] prod_x_ff, prod_y_ff;

   // box table and search pipe
   box_type          mem [MAX_BOXES];
   box_type          rd_box_ff;
   logic [CW-1:0]    iss_ff;
   logic [AW-1:0]    iss_addr;
   logic [AW-1:0]    rd_idx_ff;
   logic             rd_vld_ff;
   logic [CW-1:0]    n_items;
   logic [8:0]       items_9;
   logic             box_wr;
   logic             hit_now;
   logic signed [17:0] cx, cy;

   // step, then clamp to the screen edges less two pixels
   function automatic logic [15:0] axis_next(
      input logic [15:0]        pos,
      input logic signed [24:0] prod,
      input logic               filt,
      input logic [12:0]        size
   );
      logic signed [24:0] bias;
      logic signed [24:0] step;
      logic signed [25:0] v;
      logic [12:0]        span;
      logic [16:0]        hi;
      logic [15:0]        res;
      bias = prod[24] ? (filt ? 25'sd31 : 25'sd15) : 25'sd0;
      step = filt ? ((prod + bias) >>> 5) : ((prod + bias) >>> 4);
      v    = 26'(step) + $signed({10'd0, pos});
      span = size - 13'd2;
      if (size < 13'd4)         hi = 17'd32;
      else if (size > 13'd4097) hi = 17'd65535;
      else                      hi = {1'b0, span[11:0], 4'd0};
      if (v < 26'sd32)                       res = 16'd32;
      else if (v > $signed({9'd0, hi}))      res = hi[15:0];
      else                                   res = v[15:0];
      return res;
   endfunction

   assign items_9  = {2'b00, items_ff};
   assign n_items  = CW'((items_9 > MAX_N) ? MAX_N : items_9);
   assign iss_addr = iss_ff[AW-1:0];
   assign box_wr   = cmd.accept && req_type == REQ_BOX && 32'(req_box_index) < MAX_BOXES;

   assign cx = $signed({2'b00, pos_x_ff});
   assign cy = $signed({2'b00, pos_y_ff});

   // edges are inclusive
   assign hit_now = rd_vld_ff && rd_box_ff.selectable &&
                    !(cx > $signed({rd_box_ff.right, 4'd0})  ||
                      cy > $signed({rd_box_ff.bottom, 4'd0}) ||
                      cx < $signed({rd_box_ff.left, 4'd0})   ||
                      cy < $signed({rd_box_ff.top, 4'd0}));

   assign st.kind          = req_type;
   assign st.lock          = lock_ff;
   assign st.search_needed = (dx_ff != 12'sd0 || dy_ff != 12'sd0) && items_ff != 7'd0;
   assign st.search_done   = hit_now || (iss_ff == n_items && !rd_vld_ff);

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      if (cmd.accept && req_type == REQ_SET) begin
         pos_x_in = req_new_pos_x;
         pos_y_in = req_new_pos_y;
      end else if (cmd.upd) begin
         pos_x_in = axis_next(pos_x_ff, prod_x_ff, filt_ff, width_ff);
         pos_y_in = axis_next(pos_y_ff, prod_y_ff, filt_ff, height_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff   <= 12'd256;
         filt_ff   <= 1'b0;
         lock_ff   <= 1'b0;
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
         items_ff  <= 7'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SENSITIVITY:   sens_ff   <= csr_wdata[11:0];
            CSR_FILTER_ENABLE: filt_ff   <= csr_wdata[0];
            CSR_CURSOR_LOCK:   lock_ff   <= csr_wdata[0];
            CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            CSR_ITEM_COUNT:    items_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         hover_ff     <= 1'b0;
         hover_idx_ff <= '0;
         sel_ff       <= '0;
         changed_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         iss_ff       <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         if (cmd.upd && st.search_needed) begin
            hover_ff   <= 1'b0;
            changed_ff <= 1'b0;
            iss_ff     <= '0;
            rd_vld_ff  <= 1'b0;
         end else if (cmd.search) begin
            if (iss_ff < n_items) begin
               rd_vld_ff <= 1'b1;
               iss_ff    <= iss_ff + CW'(1);
            end else begin
               rd_vld_ff <= 1'b0;
            end
            if (hit_now) begin
               hover_ff     <= 1'b1;
               hover_idx_ff <= 6'(rd_idx_ff);
               if (sel_ff != 6'(rd_idx_ff)) begin
                  changed_ff <= 1'b1;
                  sel_ff     <= 6'(rd_idx_ff);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         dx_ff <= req_delta_x;
         dy_ff <= req_delta_y;
      end
      if (cmd.mul) begin
         prod_x_ff <= 25'(dx_ff) * 25'($signed({1'b0, sens_ff}));
         prod_y_ff <= 25'(dy_ff) * 25'($signed({1'b0, sens_ff}));
      end
      rd_idx_ff <= iss_addr;
      if (cmd.rsp_load) begin
         rsp_cursor_x       <= pos_x_ff;
         rsp_cursor_y       <= pos_y_ff;
         rsp_over_item      <= hover_ff;
         rsp_hover_index    <= hover_idx_ff;
         rsp_selected_index <= sel_ff;
         rsp_new_item       <= changed_ff;
      end
   end

   // box table, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (box_wr) begin
         mem[AW'(req_box_index)] <= '{left: req_box_left, top: req_box_top,
                                      right: req_box_right, bottom: req_box_bottom,
                                      selectable: req_box_selectable};
      end
      rd_box_ff <= mem[iss_addr];
   end

endmodule

FILE: sv/cursor_tracker_box_hit_test.sv
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// req      in         req_valid / req_stall  req_type, deltas, box entry, new position
// rsp      out        rsp_valid / rsp_stall  cursor, hover, selection, new_item
// csr      in         csr_we                 csr_index, csr_wdata
//
// one beat in at a time; box writes, set position, locked moves and unused
// kinds go from idle straight to the output state; a move steps through
// multiply and update, then, if nonzero with items set, the box search: one
// table read a cycle, at most min(item_count, MAX_BOXES), ending early on a hit
// the next beat is taken while a finished result waits on rsp_stall
// synchronous reset clears cursor and flags, loads csr defaults; table not cleared

module cursor_tracker_box_hit_test #(
   parameter int MAX_BOXES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_type,
   input  logic signed [11:0]  req_delta_x,
   input  logic signed [11:0]  req_delta_y,
   input  logic [5:0]          req_box_index,
   input  logic signed [13:0]  req_box_left,
   input  logic signed [13:0]  req_box_top,
   input  logic signed [13:0]  req_box_right,
   input  logic signed [13:0]  req_box_bottom,
   input  logic                req_box_selectable,
   input  logic [15:0]         req_new_pos_x,
   input  logic [15:0]         req_new_pos_y,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [15:0]         rsp_cursor_x,
   output logic [15:0]         rsp_cursor_y,
   output logic                rsp_over_item,
   output logic [5:0]          rsp_hover_index,
   output logic [5:0]          rsp_selected_index,
   output logic                rsp_new_item,
   input  logic                csr_we,
   input  logic [cthb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cthb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cthb_pkg::*;

   cmd_type    cmd;
   status_type st;

   cthb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .cmd       (cmd)
   );

   cthb_dpath #(
      .MAX_BOXES (MAX_BOXES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_type           (req_type),
      .req_delta_x        (req_delta_x),
      .req_delta_y        (req_delta_y),
      .req_box_index      (req_box_index),
      .req_box_left       (req_box_left),
      .req_box_top        (req_box_top),
      .req_box_right      (req_box_right),
      .req_box_bottom     (req_box_bottom),
      .req_box_selectable (req_box_selectable),
      .req_new_pos_x      (req_new_pos_x),
      .req_new_pos_y      (req_new_pos_y),
      .rsp_cursor_x       (rsp_cursor_x),
      .rsp_cursor_y       (rsp_cursor_y),
      .rsp_over_item      (rsp_over_item),
      .rsp_hover_index    (rsp_hover_index),
      .rsp_selected_index (rsp_selected_index),
      .rsp_new_item       (rsp_new_item)
   );

endmodule

FILE: sv/cthb_check.sv
`timescale 1ns / 1ps

module cthb_check (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [15:0]         rsp_cursor_x,
   input logic [15:0]         rsp_cursor_y,
   input logic                rsp_over_item,
   input logic [5:0]          rsp_hover_index,
   input logic [5:0]          rsp_selected_index,
   input logic                rsp_new_item
);

   // result beat holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cursor_x) &&
      $stable(rsp_cursor_y) && $stable(rsp_selected_index))
      else $error("rsp beat dropped or changed under stall");

   // one request in flight at a time
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // a change of selection only comes from a hit
   a_new_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_item |-> rsp_over_item)
      else $error("new_item without over_item");

   // a hit always becomes the selection
   a_hover_is_sel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_over_item |-> rsp_hover_index == rsp_selected_index)
      else $error("hover index differs from selection");

endmodule

bind cursor_tracker_box_hit_test cthb_check u_cthb_check (.*);
